// File: design/apsp_pkg.sv
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared types and codes for the all-pairs shortest path block: transfer
// payloads, operation codes, and the microcode word of the sequencer.
// ----------------------------------------------------------------------------
package apsp_pkg;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  row;
        logic [4:0]  col;
        logic [15:0] weight;
    } t_in;

    typedef struct packed {
        logic [15:0] distance;
        logic [4:0]  predecessor;
        logic        done_res;
    } t_out;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RELAX = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // distance read select
    localparam logic [1:0] DRD_NONE = 2'd0;
    localparam logic [1:0] DRD_IK   = 2'd1;
    localparam logic [1:0] DRD_KJ   = 2'd2;
    localparam logic [1:0] DRD_IJ   = 2'd3;

    // counter advance mode
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_IJ   = 2'd1;
    localparam logic [1:0] CNT_KIJ  = 2'd2;

    // microcode steps
    localparam logic [2:0] UC_IDLE  = 3'd0;
    localparam logic [2:0] UC_INIT  = 3'd1;
    localparam logic [2:0] UC_RD_IK = 3'd2;
    localparam logic [2:0] UC_RD_KJ = 3'd3;
    localparam logic [2:0] UC_RD_IJ = 3'd4;
    localparam logic [2:0] UC_UPD   = 3'd5;
    localparam logic [2:0] UC_DONE  = 3'd6;

    typedef struct packed {
        logic [1:0] d_rd;
        logic       p_rd;
        logic       cap_ik;
        logic       cap_kj;
        logic       init_wr;
        logic       upd_wr;
        logic [1:0] cnt;
        logic       done;
        logic [2:0] jmp_last;
        logic [2:0] jmp_else;
    } t_uword;

endpackage

// File: design/all_pairs_shortest_path_top.sv
// Write: no result. Query: result strobed the cycle after the transfer.
// Relax: busy for the init pass and the k/i/j loop, then one done strobe;
//   four steps per relaxation, set by the single read port of the distance RAM.
// When idle, writes and queries can follow every cycle; results cannot be stalled.
// Reset (synchronous, active low) clears control and loop counters; matrix RAMs
//   are not cleared and hold undefined data until written. node_total resets to 32.
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_top
// Floyd-Warshall all-pairs shortest paths over a distance/predecessor matrix
// held in RAM, driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_top #(
    parameter int MAX_NODES = 32,
    parameter int DIST_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  apsp_pkg::t_in   i_in,
    output logic            o_strobe,
    output apsp_pkg::t_out  o_res,
    input  logic            i_cfg_we,
    input  logic [5:0]      i_cfg_wdata
);
    import apsp_pkg::*;

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int AW    = 2 * IDX_W;
    localparam int DEPTH = 1 << AW;
    localparam int NW    = ($clog2(MAX_NODES + 1) > 6) ? $clog2(MAX_NODES + 1) : 6;

    logic [5:0]           r_node_total;
    logic [IDX_W-1:0]     r_k, r_i, r_j;
    logic [IDX_W-1:0]     n_k, n_i, n_j;
    logic [DIST_BITS-1:0] r_dik, r_dkj;
    logic                 r_strobe, r_done, r_qok;

    t_uword               w_ctl;
    logic                 w_acc, w_in_inside, w_last;
    logic                 w_last_k, w_last_i, w_last_j;
    logic [NW-1:0]        w_total, w_n, w_nm1;
    logic [AW-1:0]        w_in_addr, w_ij, w_ik, w_kj;

    logic                 w_d_we, w_d_re;
    logic [AW-1:0]        w_d_waddr, w_d_raddr;
    logic [DIST_BITS-1:0] w_d_wdata, w_d_rdata;
    logic                 w_p_we, w_p_re;
    logic [AW-1:0]        w_p_raddr;
    logic [IDX_W-1:0]     w_p_wdata, w_p_rdata;

    logic [DIST_BITS:0]   w_sum;
    logic [DIST_BITS-1:0] w_via;
    logic                 w_upd;

    assign w_acc       = start && !busy;
    assign w_in_inside = (32'(i_in.row) < MAX_NODES) && (32'(i_in.col) < MAX_NODES);
    assign w_in_addr   = {IDX_W'(i_in.row), IDX_W'(i_in.col)};
    assign w_ij        = {r_i, r_j};
    assign w_ik        = {r_i, r_k};
    assign w_kj        = {r_k, r_j};

    assign w_total  = NW'(r_node_total);
    assign w_n      = (w_total > NW'(MAX_NODES)) ? NW'(MAX_NODES) : w_total;
    assign w_nm1    = w_n - NW'(1);
    assign w_last_k = (NW'(r_k) == w_nm1);
    assign w_last_i = (NW'(r_i) == w_nm1);
    assign w_last_j = (NW'(r_j) == w_nm1);

    always_comb begin
        case (w_ctl.cnt)
            CNT_IJ:  w_last = w_last_i && w_last_j;
            CNT_KIJ: w_last = w_last_k && w_last_i && w_last_j;
            default: w_last = 1'b0;
        endcase
    end

    apsp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_acc && (i_in.op == OP_RELAX)),
        .i_skip  (w_n == '0),
        .i_last  (w_last),
        .o_ctl   (w_ctl),
        .o_busy  (busy)
    );

    // loop counters: j innermost, then i, then k
    always_comb begin
        n_k = r_k;
        n_i = r_i;
        n_j = r_j;
        if (w_ctl.cnt != CNT_NONE) begin
            if (!w_last_j) begin
                n_j = r_j + IDX_W'(1);
            end else begin
                n_j = '0;
                if (!w_last_i) begin
                    n_i = r_i + IDX_W'(1);
                end else begin
                    n_i = '0;
                    if (w_ctl.cnt == CNT_KIJ) begin
                        n_k = w_last_k ? '0 : r_k + IDX_W'(1);
                    end
                end
            end
        end
    end

    assign w_sum = {1'b0, r_dik} + {1'b0, r_dkj};
    assign w_via = w_sum[DIST_BITS] ? '1 : w_sum[DIST_BITS-1:0];
    assign w_upd = w_ctl.upd_wr && (w_d_rdata > w_via);

    always_comb begin
        w_d_raddr = w_in_addr;
        w_d_re    = 1'b1;
        case (w_ctl.d_rd)
            DRD_IK:  w_d_raddr = w_ik;
            DRD_KJ:  w_d_raddr = w_kj;
            DRD_IJ:  w_d_raddr = w_ij;
            default: w_d_re    = w_acc && (i_in.op == OP_QUERY);
        endcase
    end

    assign w_d_we    = w_upd || (w_acc && (i_in.op == OP_WRITE) && w_in_inside);
    assign w_d_waddr = w_ctl.upd_wr ? w_ij : w_in_addr;
    assign w_d_wdata = w_ctl.upd_wr ? w_via : DIST_BITS'(i_in.weight);

    assign w_p_re    = w_ctl.p_rd || (w_acc && (i_in.op == OP_QUERY));
    assign w_p_raddr = w_ctl.p_rd ? w_kj : w_in_addr;
    assign w_p_we    = w_ctl.init_wr || w_upd;
    assign w_p_wdata = w_ctl.init_wr ? r_i : w_p_rdata;

    apsp_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (DEPTH)
    ) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (w_d_we),
        .i_waddr (w_d_waddr),
        .i_wdata (w_d_wdata),
        .i_re    (w_d_re),
        .i_raddr (w_d_raddr),
        .o_rdata (w_d_rdata)
    );

    apsp_ram #(
        .WIDTH (IDX_W),
        .DEPTH (DEPTH)
    ) u_pred_ram (
        .i_clk   (i_clk),
        .i_we    (w_p_we),
        .i_waddr (w_ij),
        .i_wdata (w_p_wdata),
        .i_re    (w_p_re),
        .i_raddr (w_p_raddr),
        .o_rdata (w_p_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (w_ctl.cap_ik) begin
            r_dik <= w_d_rdata;
        end
        if (w_ctl.cap_kj) begin
            r_dkj <= w_d_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_total <= 6'd32;
            r_k          <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_strobe     <= 1'b0;
            r_done       <= 1'b0;
            r_qok        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_total <= i_cfg_wdata;
            end
            r_k      <= n_k;
            r_i      <= n_i;
            r_j      <= n_j;
            r_strobe <= (w_acc && (i_in.op == OP_QUERY)) || w_ctl.done;
            r_done   <= w_ctl.done;
            r_qok    <= w_acc && (i_in.op == OP_QUERY) && w_in_inside;
        end
    end

    assign o_strobe          = r_strobe;
    assign o_res.distance    = r_qok ? 16'(w_d_rdata) : '0;
    assign o_res.predecessor = r_qok ? 5'(w_p_rdata) : '0;
    assign o_res.done_res    = r_done;

    a_relax_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_in.op == OP_RELAX)) |=> busy)
        else $error("relax transfer did not start the sequencer");

    a_query_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_in.op == OP_QUERY)) |=> (o_strobe && !o_res.done_res))
        else $error("query transfer gave no result");

    a_done_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.done |=> (o_strobe && o_res.done_res && !busy))
        else $error("relax end gave no done result");

    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (r_k == '0 && r_i == '0 && r_j == '0))
        else $error("loop counters not cleared while idle");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (NW'(r_k) <= w_nm1 && NW'(r_i) <= w_nm1 && NW'(r_j) <= w_nm1))
        else $error("loop counter beyond active node count");

endmodule

// File: design/apsp_ram.sv
// ----------------------------------------------------------------------------
// apsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module apsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/apsp_seq.sv
// ----------------------------------------------------------------------------
// apsp_seq
// Microcode sequencer: step counter, control ROM and conditional jumps for
// the predecessor init pass and the k/i/j relaxation loop.
// ----------------------------------------------------------------------------
module apsp_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  logic            i_skip,
    input  logic            i_last,
    output apsp_pkg::t_uword o_ctl,
    output logic            o_busy
);
    import apsp_pkg::*;

    logic [2:0] r_pc;
    logic [2:0] n_pc;
    t_uword     w_rom;

    always_comb begin
        w_rom = '0;
        case (r_pc)
            UC_IDLE: begin
                w_rom.jmp_else = UC_IDLE;
            end
            UC_INIT: begin
                w_rom.init_wr  = 1'b1;
                w_rom.cnt      = CNT_IJ;
                w_rom.jmp_last = UC_RD_IK;
                w_rom.jmp_else = UC_INIT;
            end
            UC_RD_IK: begin
                w_rom.d_rd     = DRD_IK;
                w_rom.jmp_else = UC_RD_KJ;
            end
            UC_RD_KJ: begin
                w_rom.d_rd     = DRD_KJ;
                w_rom.cap_ik   = 1'b1;
                w_rom.jmp_else = UC_RD_IJ;
            end
            UC_RD_IJ: begin
                w_rom.d_rd     = DRD_IJ;
                w_rom.p_rd     = 1'b1;
                w_rom.cap_kj   = 1'b1;
                w_rom.jmp_else = UC_UPD;
            end
            UC_UPD: begin
                w_rom.upd_wr   = 1'b1;
                w_rom.cnt      = CNT_KIJ;
                w_rom.jmp_last = UC_DONE;
                w_rom.jmp_else = UC_RD_IK;
            end
            UC_DONE: begin
                w_rom.done     = 1'b1;
                w_rom.jmp_else = UC_IDLE;
            end
            default: begin
                w_rom.jmp_else = UC_IDLE;
            end
        endcase
    end

    always_comb begin
        if (r_pc == UC_IDLE) begin
            if (i_go) begin
                n_pc = i_skip ? UC_DONE : UC_INIT;
            end else begin
                n_pc = UC_IDLE;
            end
        end else begin
            n_pc = i_last ? w_rom.jmp_last : w_rom.jmp_else;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl  = w_rom;
    assign o_busy = (r_pc != UC_IDLE);

endmodule

// File: tb/tb_all_pairs_shortest_path_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_all_pairs_shortest_path_top
// Self-checking bench for the all-pairs shortest path block. A scoreboard
// class keeps its own distance and predecessor matrices, repeats every write,
// relaxation and query transfer on them and checks each strobed result in
// order. The matrix is first loaded whole at the reset node count; then come
// directed corner, saturation and tie cases, and random phases over many node
// counts, with random idle cycles on the command side outside phases 8 to 12.
// ----------------------------------------------------------------------------
module tb_all_pairs_shortest_path_top;
    import apsp_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int QUIET_LIMIT = 600_000;
    localparam int RANDOM_ITEMS = 480;

    class path_scoreboard;
        logic [15:0] dist_mx [0:1023];
        logic [4:0]  pred_mx [0:1023];
        logic [5:0]  node_total;
        t_out        expected_answers [$];

        function new();
            node_total = 6'd32;
        endfunction

        function void set_nodes(logic [5:0] v);
            node_total = v;
        endfunction

        function void relax_matrix();
            int n;
            logic [16:0] sum;
            logic [15:0] via;
            logic [9:0] ij, ik, kj;
            n = (node_total > 6'd32) ? 32 : int'(node_total);
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                    pred_mx[10'(i * 32 + j)] = i[4:0];
            for (int k = 0; k < n; k++)
                for (int i = 0; i < n; i++)
                    for (int j = 0; j < n; j++) begin
                        ij = 10'(i * 32 + j);
                        ik = 10'(i * 32 + k);
                        kj = 10'(k * 32 + j);
                        sum = {1'b0, dist_mx[ik]} + {1'b0, dist_mx[kj]};
                        via = sum[16] ? 16'hFFFF : sum[15:0];
                        if (dist_mx[ij] > via) begin
                            pred_mx[ij] = pred_mx[kj];
                            dist_mx[ij] = via;
                        end
                    end
        endfunction

        function void note_input(t_in it);
            t_out r;
            logic [9:0] idx;
            idx = {it.row, it.col};
            case (it.op)
                OP_WRITE: dist_mx[idx] = it.weight;
                OP_RELAX: begin
                    relax_matrix();
                    r.distance = '0;
                    r.predecessor = '0;
                    r.done_res = 1'b1;
                    expected_answers.push_back(r);
                end
                OP_QUERY: begin
                    r.distance = dist_mx[idx];
                    r.predecessor = pred_mx[idx];
                    r.done_res = 1'b0;
                    expected_answers.push_back(r);
                end
                default: ;
            endcase
        endfunction

        // empty string on a match
        function string check_result(t_out got);
            t_out exp_r;
            string msg;
            msg = "";
            if (expected_answers.size() == 0)
                return $sformatf("unexpected result dist=%0d pred=%0d done=%0b",
                                 got.distance, got.predecessor, got.done_res);
            exp_r = expected_answers.pop_front();
            if (got.distance !== exp_r.distance)
                msg = {msg, $sformatf(" distance %0d/%0d", got.distance, exp_r.distance)};
            if (got.predecessor !== exp_r.predecessor)
                msg = {msg, $sformatf(" predecessor %0d/%0d",
                                      got.predecessor, exp_r.predecessor)};
            if (got.done_res !== exp_r.done_res)
                msg = {msg, $sformatf(" done_res %0b/%0b", got.done_res, exp_r.done_res)};
            if (msg != "")
                msg = {"result field got/exp:", msg};
            return msg;
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_in        i_in = '0;
    logic       o_strobe;
    t_out       o_res;
    logic       i_cfg_we = 1'b0;
    logic [5:0] i_cfg_wdata = '0;

    path_scoreboard sb = new();
    int  mismatch_count = 0;
    int  work_items = 0;
    int  quiet_cycles = 0;
    bit  idle_on = 1'b1;

    all_pairs_shortest_path_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_strobe    (o_strobe),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t ns: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_strobe) begin
            msg = sb.check_result(o_res);
            if (msg != "")
                report_mismatch(msg);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_in mk_item(logic [1:0] op, int r, int c, int w);
        t_in it;
        it.op = op;
        it.row = r[4:0];
        it.col = c[4:0];
        it.weight = w[15:0];
        return it;
    endfunction

    function automatic int rand_weight();
        case ($urandom_range(9))
            0: return 0;
            1: return 16'hFFFF;
            2: return $urandom_range(65000, 65535);
            3: return $urandom_range(65535);
            default: return $urandom_range(1, 200);
        endcase
    endfunction

    // one transfer; returns in the time step of the accepting edge
    task automatic send_item(input t_in it);
        while (idle_on && $urandom_range(99) < 18) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        sb.note_input(it);
        if (it.op != OP_NONE)
            work_items++;
    endtask

    task automatic send_noise();
        send_item(mk_item(OP_NONE, $urandom_range(31), $urandom_range(31),
                          $urandom_range(65535)));
    endtask

    task automatic send_relax();
        send_item(mk_item(OP_RELAX, $urandom_range(31), $urandom_range(31),
                          $urandom_range(65535)));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_node_total(input logic [5:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_nodes(v);
    endtask

    task automatic run_random_phase(input logic [5:0] nodes);
        int lim;
        int rounds;
        lim = (nodes == 0) ? 1 : ((nodes > 6'd32) ? 32 : int'(nodes));
        set_node_total(nodes);
        rounds = (lim > 12) ? 1 : $urandom_range(1, 3);
        repeat (rounds) begin
            repeat ($urandom_range(1, 16)) begin
                case ($urandom_range(19))
                    0: send_noise();
                    1, 2: send_item(mk_item(OP_QUERY, $urandom_range(31),
                                            $urandom_range(31), $urandom_range(65535)));
                    3: send_item(mk_item(OP_WRITE, $urandom_range(31),
                                         $urandom_range(31), rand_weight()));
                    default: send_item(mk_item(OP_WRITE, $urandom_range(lim - 1),
                                               $urandom_range(lim - 1), rand_weight()));
                endcase
            end
            send_relax();
            repeat ($urandom_range(3, 12)) begin
                case ($urandom_range(19))
                    0: send_noise();
                    1: send_item(mk_item(OP_WRITE, $urandom_range(lim - 1),
                                         $urandom_range(lim - 1), rand_weight()));
                    2, 3: send_item(mk_item(OP_QUERY, $urandom_range(31),
                                            $urandom_range(31), $urandom_range(65535)));
                    default: send_item(mk_item(OP_QUERY, $urandom_range(lim - 1),
                                               $urandom_range(lim - 1),
                                               $urandom_range(65535)));
                endcase
            end
        end
    endtask

    function automatic logic [5:0] pick_nodes(int phase);
        int r;
        if (phase == 5)
            return 6'd63;
        r = $urandom_range(99);
        if (r < 3)
            return 6'd0;
        if (r < 75)
            return 6'($urandom_range(1, 8));
        return 6'($urandom_range(9, 16));
    endfunction

    initial begin
        int base;
        int phase;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full load at the reset node count, every cell written before any read
        for (int r = 0; r < 32; r++)
            for (int c = 0; c < 32; c++)
                send_item(mk_item(OP_WRITE, r, c, rand_weight()));

        // corners and ignored op at reset size
        send_item(mk_item(OP_WRITE, 0, 0, 0));
        send_item(mk_item(OP_WRITE, 31, 31, 16'hFFFF));
        send_item(mk_item(OP_WRITE, 0, 31, 16'hFFFF));
        send_item(mk_item(OP_WRITE, 31, 0, 0));
        send_item(mk_item(OP_NONE, 31, 31, 16'hFFFF));
        send_relax();
        send_item(mk_item(OP_QUERY, 0, 0, 0));
        send_item(mk_item(OP_QUERY, 31, 31, 16'hFFFF));
        send_item(mk_item(OP_QUERY, 0, 31, 0));
        send_item(mk_item(OP_QUERY, 31, 0, 16'hFFFF));

        // zero nodes: acknowledged, nothing touched
        set_node_total(6'd0);
        send_relax();
        send_item(mk_item(OP_QUERY, 1, 1, 0));

        set_node_total(6'd1);
        send_relax();
        send_item(mk_item(OP_QUERY, 0, 0, 0));

        // saturating path on (0,2), equal-cost path on (2,0)
        set_node_total(6'd3);
        send_item(mk_item(OP_WRITE, 0, 1, 40000));
        send_item(mk_item(OP_WRITE, 1, 2, 40000));
        send_item(mk_item(OP_WRITE, 0, 2, 16'hFFFF));
        send_item(mk_item(OP_WRITE, 2, 1, 3));
        send_item(mk_item(OP_WRITE, 1, 0, 4));
        send_item(mk_item(OP_WRITE, 2, 0, 7));
        send_relax();
        send_item(mk_item(OP_QUERY, 0, 2, 0));
        send_item(mk_item(OP_QUERY, 2, 0, 0));

        base = work_items;
        phase = 0;
        while (work_items - base < RANDOM_ITEMS) begin
            idle_on = !(phase >= 8 && phase <= 12);
            run_random_phase(pick_nodes(phase));
            phase++;
        end

        idle_on = 1'b1;
        drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
